@@ rtl/bsse_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bsse_pkg;

   localparam int WORDS    = 1024;
   localparam int WORD_W   = 32;
   localparam int IDX_W    = $clog2(WORDS);
   localparam int USED_W   = $clog2(WORDS) + 1;
   localparam int SIZE_W   = 16;
   localparam int POS_W    = IDX_W + 5;
   localparam int MAX_BITS = WORDS * WORD_W;
   localparam int OP_W     = 4;
   localparam int ADDR_W   = 32;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD   = 4'd0,
      OP_READ   = 4'd1,
      OP_FIRST  = 4'd2,
      OP_NEXT   = 4'd3,
      OP_COUNT  = 4'd4,
      OP_OR     = 4'd5,
      OP_AND    = 4'd6,
      OP_ANDNOT = 4'd7,
      OP_NEGATE = 4'd8
   } op_type;

   typedef enum logic {
      CSR_BASE = 1'b0,
      CSR_SIZE = 1'b1
   } csr_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_WORD,
      ST_SCAN,
      ST_COUNT,
      ST_DONE
   } state_type;

   function automatic logic [5:0] popcount32(input logic [WORD_W-1:0] v);
      logic [WORD_W-1:0] v1;
      logic [WORD_W-1:0] v2;
      logic [WORD_W-1:0] v3;
      logic [7:0]        sum;
      v1  = v - ((v >> 1) & 32'h5555_5555);
      v2  = (v1 & 32'h3333_3333) + ((v1 >> 2) & 32'h3333_3333);
      v3  = (v2 + (v2 >> 4)) & 32'h0f0f_0f0f;
      sum = v3[7:0] + v3[15:8] + v3[23:16] + v3[31:24];
      return sum[5:0];
   endfunction

   // priority encoder, lowest set bit wins
   function automatic logic [4:0] lowest_bit(input logic [WORD_W-1:0] v);
      logic [4:0] n;
      n = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (v[i]) n = 5'(i);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

@@ rtl/bsse_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface bsse_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  opcode;
   logic [9:0]  word_index;
   logic [31:0] data_word;
   logic [31:0] address;

   modport source (output valid, opcode, word_index, data_word, address, input ready);
   modport sink   (input valid, opcode, word_index, data_word, address, output ready);
endinterface

interface bsse_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [31:0] found_address;
   logic [31:0] result_word;
   logic [15:0] bit_count;

   modport source (output valid, found, found_address, result_word, bit_count, input ready);
   modport sink   (input valid, found, found_address, result_word, bit_count, output ready);
endinterface

`default_nettype wire

@@ rtl/bitmap_set_scan_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Bitmap set engine: 1024 x 32-bit bitmap in a single-port-read, single-port-write
// RAM. One transaction is processed at a time. After reset the block sweeps the RAM
// to zero and holds req_ch.ready low meanwhile. Load and unknown opcodes go from the
// start state to done, and load writes its word in start; read and the combine opcodes
// read in start and form the result in the word state; first, next and count visit
// one bitmap word per step, up to ceil(size/32) words (1024 at most), since the RAM
// read port delivers one word a cycle. The result sits in an output register, so the
// next transaction may be accepted while it waits to be taken.

module bitmap_set_scan_engine (
   input  wire logic                   clock,
   input  wire logic                   reset,
   bsse_req_if.sink                    req_ch,
   bsse_rsp_if.source                  rsp_ch,
   input  wire logic                   csr_we,
   input  wire bsse_pkg::csr_type      csr_index,
   input  wire logic [31:0]            csr_wdata
);

   import bsse_pkg::*;

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    clr_ff, clr_in;
   logic [ADDR_W-1:0]   base_ff;
   logic [SIZE_W-1:0]   size_ff;

   op_type              op_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic [WORD_W-1:0]   data_ff;
   logic [ADDR_W-1:0]   addr_ff;

   logic [IDX_W-1:0]    cur_w_ff, cur_w_in;
   logic                first_ff, first_in;
   logic [WORD_W-1:0]   mask_ff, mask_in;
   logic [SIZE_W-1:0]   cnt_ff, cnt_in;
   logic                found_ff, found_in;
   logic [ADDR_W-1:0]   faddr_ff, faddr_in;
   logic [WORD_W-1:0]   word_ff, word_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff;
   logic [ADDR_W-1:0]   rsp_faddr_ff;
   logic [WORD_W-1:0]   rsp_word_ff;
   logic [SIZE_W-1:0]   rsp_cnt_ff;
   logic                rsp_load;

   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   logic [WORD_W-1:0]   mem_wdata;
   logic                mem_re;
   logic [IDX_W-1:0]    mem_raddr;
   logic [WORD_W-1:0]   mem_rdata;

   logic [SIZE_W-1:0]   eff_size;
   logic [USED_W-1:0]   used;
   logic [ADDR_W-1:0]   offset;
   logic [WORD_W-1:0]   scan_v;
   logic [WORD_W-1:0]   last_mask;
   logic [WORD_W-1:0]   cnt_v;
   logic [USED_W-1:0]   next_w;
   logic [POS_W-1:0]    pos;
   logic                accept;

   bsse_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // effective size and number of words in use
   assign eff_size = (size_ff > SIZE_W'(MAX_BITS)) ? SIZE_W'(MAX_BITS) : size_ff;
   assign used     = USED_W'((17'(eff_size) + 17'd31) >> 5);
   assign offset   = addr_ff - base_ff;
   assign next_w   = USED_W'(cur_w_ff) + USED_W'(1);

   assign scan_v    = mem_rdata & (first_ff ? mask_ff : '1);
   assign pos       = {cur_w_ff, lowest_bit(scan_v)};
   assign last_mask = (eff_size[4:0] == 5'd0) ? '1 : ~({WORD_W{1'b1}} << eff_size[4:0]);
   assign cnt_v     = (next_w == used) ? (mem_rdata & last_mask) : mem_rdata;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         size_ff <= SIZE_W'(MAX_BITS);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BASE: base_ff <= csr_wdata;
            CSR_SIZE: size_ff <= csr_wdata[SIZE_W-1:0];
            default:  ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= op_type'(req_ch.opcode);
         idx_ff  <= req_ch.word_index;
         data_ff <= req_ch.data_word;
         addr_ff <= req_ch.address;
      end
      cur_w_ff <= cur_w_in;
      first_ff <= first_in;
      mask_ff  <= mask_in;
      cnt_ff   <= cnt_in;
      found_ff <= found_in;
      faddr_ff <= faddr_in;
      word_ff  <= word_in;
      if (rsp_load) begin
         rsp_found_ff <= found_ff;
         rsp_faddr_ff <= faddr_ff;
         rsp_word_ff  <= word_ff;
         rsp_cnt_ff   <= cnt_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cur_w_in     = cur_w_ff;
      first_in     = first_ff;
      mask_in      = mask_ff;
      cnt_in       = cnt_ff;
      found_in     = found_ff;
      faddr_in     = faddr_ff;
      word_in      = word_ff;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff;
      mem_wdata    = data_ff;
      mem_re       = 1'b0;
      mem_raddr    = idx_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(WORDS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = ST_START;
         end
         ST_START: begin
            cnt_in   = '0;
            found_in = 1'b0;
            faddr_in = '0;
            word_in  = '0;
            cur_w_in = '0;
            first_in = 1'b1;
            mask_in  = '1;
            state_in = ST_DONE;
            unique case (op_ff)
               OP_LOAD: begin
                  mem_we = 1'b1;
               end
               OP_READ, OP_OR, OP_AND, OP_ANDNOT, OP_NEGATE: begin
                  mem_re   = 1'b1;
                  state_in = ST_WORD;
               end
               OP_FIRST, OP_COUNT: begin
                  mem_raddr = '0;
                  if (used != '0) begin
                     mem_re   = 1'b1;
                     state_in = (op_ff == OP_COUNT) ? ST_COUNT : ST_SCAN;
                  end
               end
               OP_NEXT: begin
                  // search starts just above the given bit; bit 31 leaves an empty mask
                  mem_raddr = offset[IDX_W+4:5];
                  cur_w_in  = offset[IDX_W+4:5];
                  mask_in   = ({WORD_W{1'b1}} << offset[4:0]) << 1;
                  if (offset[31:5] < 27'(used)) begin
                     mem_re   = 1'b1;
                     state_in = ST_SCAN;
                  end
               end
               default: ;
            endcase
         end
         ST_WORD: begin
            unique case (op_ff)
               OP_OR:     word_in = mem_rdata | data_ff;
               OP_AND:    word_in = mem_rdata & data_ff;
               OP_ANDNOT: word_in = mem_rdata & ~data_ff;
               OP_NEGATE: word_in = ~mem_rdata;
               default:   word_in = mem_rdata;
            endcase
            state_in = ST_DONE;
         end
         ST_SCAN: begin
            first_in = 1'b0;
            if (scan_v != '0) begin
               // the first set bit met ends the search, even past the size
               if (SIZE_W'(pos) < eff_size) begin
                  found_in = 1'b1;
                  faddr_in = base_ff + ADDR_W'(pos);
               end
               state_in = ST_DONE;
            end else if (next_w >= used) begin
               state_in = ST_DONE;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = next_w[IDX_W-1:0];
               cur_w_in  = next_w[IDX_W-1:0];
            end
         end
         ST_COUNT: begin
            cnt_in = cnt_ff + SIZE_W'(popcount32(cnt_v));
            if (next_w == used) begin
               state_in = ST_DONE;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = next_w[IDX_W-1:0];
               cur_w_in  = next_w[IDX_W-1:0];
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.found         = rsp_found_ff;
   assign rsp_ch.found_address = rsp_faddr_ff;
   assign rsp_ch.result_word   = rsp_word_ff;
   assign rsp_ch.bit_count     = rsp_cnt_ff;

   a_single_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ch.ready)
      else $error("second transaction accepted while one is in flight");

   a_write_source: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_CLEAR || (state_ff == ST_START && op_ff == OP_LOAD)))
      else $error("bitmap written outside clear pass or load");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_COUNT) |-> (USED_W'(cur_w_ff) < used))
      else $error("scan visits a word beyond the size in use");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result presented without a finished transaction");

   a_miss_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_faddr_ff == '0))
      else $error("not-found result carries an address");

endmodule

`default_nettype wire

@@ rtl/bsse_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bsse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
